### rtl/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// shared constants and types for the min tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int DATA_W        = 32;

  // operation codes on func
  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_t;

endpackage

### rtl/mts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack
// bounded signed value stack that also reports its running minimum
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high, and the receiver
// cannot stall it. push and status-only items give their result in the cycle
// after they are taken and the next item may follow at once. a pop that
// removes a value passes through ST_POP_WAIT: the entry that becomes the new
// top must be read from the value ram (and, when the minimum is popped, from
// the minima ram), whose read data is registered; busy is high for that read cycle.
// the tops of both stacks are cached in registers, so no other item needs a
// ram read. refused pushes (stack full) and refused pops (stack empty) change
// nothing, report their status code and give their result in the cycle after
// they are taken. no clearing pass is needed after reset: only entries below
// the fill counts are ever used.
// ----------------------------------------------------------------------------
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               func,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     done,
  output logic signed [DATA_W-1:0] min_value,
  output logic signed [DATA_W-1:0] top_value,
  output logic [7:0]               depth,
  output logic                     is_empty,
  output logic                     is_full,
  output logic [1:0]               status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // control state
  state_t          state, state_next;
  logic [CW-1:0]   value_count, value_count_next;
  logic [CW-1:0]   minima_count, minima_count_next;
  logic            pop_min, pop_min_next;
  logic            done_next;
  logic [1:0]      status_next;

  // cached tops of both stacks
  logic signed [DATA_W-1:0] top_cache, top_cache_next;
  logic signed [DATA_W-1:0] min_cache, min_cache_next;

  // ram ports
  logic              v_we, m_we;
  logic [AW-1:0]     v_waddr, m_waddr, v_raddr, m_raddr;
  logic [DATA_W-1:0] v_rdata, m_rdata;
  logic [CW-1:0]     value_count_m2, minima_count_m2;

  logic accept;
  logic full_now, empty_now;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign full_now  = (value_count == CW'(DEPTH));
  assign empty_now = (value_count == '0);

  // writes go to the slot just above each top
  assign v_waddr = value_count[AW-1:0];
  assign m_waddr = minima_count[AW-1:0];

  // reads fetch the entry below the current top, used after a pop
  assign value_count_m2  = value_count - CW'(2);
  assign minima_count_m2 = minima_count - CW'(2);
  assign v_raddr         = value_count_m2[AW-1:0];
  assign m_raddr         = minima_count_m2[AW-1:0];

  mts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (push_value),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  mts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_minima_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (push_value),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      value_count  <= '0;
      minima_count <= '0;
      pop_min      <= 1'b0;
      done         <= 1'b0;
      status       <= STAT_OK;
    end else begin
      state        <= state_next;
      value_count  <= value_count_next;
      minima_count <= minima_count_next;
      pop_min      <= pop_min_next;
      done         <= done_next;
      status       <= status_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_cache <= top_cache_next;
    min_cache <= min_cache_next;
  end

  always_comb begin
    state_next        = state;
    value_count_next  = value_count;
    minima_count_next = minima_count;
    pop_min_next      = pop_min;
    done_next         = 1'b0;
    status_next       = status;
    top_cache_next    = top_cache;
    min_cache_next    = min_cache;
    v_we              = 1'b0;
    m_we              = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_PUSH: begin
              done_next = 1'b1;
              if (full_now) begin
                status_next = STAT_FULL;
              end else begin
                status_next      = STAT_OK;
                v_we             = 1'b1;
                top_cache_next   = push_value;
                value_count_next = value_count + CW'(1);
                // new minimum (ties included) goes onto the minima stack
                if ((minima_count == '0) ||
                    ((minima_count != CW'(DEPTH)) && (push_value <= min_cache))) begin
                  m_we              = 1'b1;
                  min_cache_next    = push_value;
                  minima_count_next = minima_count + CW'(1);
                end
              end
            end
            FUNC_POP: begin
              if (empty_now) begin
                done_next   = 1'b1;
                status_next = STAT_EMPTY;
              end else begin
                status_next      = STAT_OK;
                value_count_next = value_count - CW'(1);
                pop_min_next     = (minima_count != '0) && (top_cache == min_cache);
                if (pop_min_next) begin
                  minima_count_next = minima_count - CW'(1);
                end
                // rams are reading the entries below the tops this cycle
                state_next = ST_POP_WAIT;
              end
            end
            default: begin
              // status only, unused code included
              done_next   = 1'b1;
              status_next = STAT_OK;
            end
          endcase
        end
      end
      ST_POP_WAIT: begin
        // refill the cached tops from the read data
        if (value_count != '0) begin
          top_cache_next = v_rdata;
        end
        if (pop_min && (minima_count != '0)) begin
          min_cache_next = m_rdata;
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result fields follow the registered state
  assign min_value = (minima_count != '0) ? min_cache : '0;
  assign top_value = empty_now ? '0 : top_cache;
  assign is_empty  = empty_now;
  assign is_full   = full_now;

  generate
    if (CW >= 8) begin : g_depth_wide
      assign depth = value_count[7:0];
    end else begin : g_depth_narrow
      assign depth = {{(8 - CW){1'b0}}, value_count};
    end
  endgenerate

endmodule

### rtl/mts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_checker
// port level checks on the min tracking stack
// ----------------------------------------------------------------------------
module mts_checker
  import mts_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               func,
  input logic                     done,
  input logic signed [DATA_W-1:0] min_value,
  input logic signed [DATA_W-1:0] top_value,
  input logic                     is_empty,
  input logic                     is_full,
  input logic [1:0]               status
);

  // an empty stack reports zero for both values
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && is_empty |-> (top_value == '0) && (min_value == '0))
    else $error("empty stack reports nonzero values");

  // minimum never exceeds the top value
  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    done && !is_empty |-> min_value <= top_value)
    else $error("minimum above top value");

  // a refused push means the stack is full, a refused pop means it is empty
  a_refusal: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status != STAT_FULL) || is_full) && ((status != STAT_EMPTY) || is_empty))
    else $error("refusal status inconsistent with fill state");

  // a taken push gives its result in the next cycle
  a_push_latency: assert property (@(posedge clk) disable iff (rst)
    !rst && start && !busy && (func == FUNC_PUSH) |=> done)
    else $error("push result missing");

  // a taken item that is not a pop never leaves the block busy
  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    !rst && start && !busy && (func != FUNC_POP) |=> !busy)
    else $error("busy after non-pop item");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .func      (func),
  .done      (done),
  .min_value (min_value),
  .top_value (top_value),
  .is_empty  (is_empty),
  .is_full   (is_full),
  .status    (status)
);

### sim/min_tracking_stack_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_check
// watches the item and result channels of the min tracking stack, keeps its
// own copy of both stacks, and compares every result field by field
// ----------------------------------------------------------------------------
module min_tracking_stack_check
  import mts_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               func,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     done,
  input  logic signed [DATA_W-1:0] min_value,
  input  logic signed [DATA_W-1:0] top_value,
  input  logic [7:0]               depth,
  input  logic                     is_empty,
  input  logic                     is_full,
  input  logic [1:0]               status,
  output int                       fail_count,
  output int                       outstanding
);

  typedef struct packed {
    logic signed [DATA_W-1:0] min_v;
    logic signed [DATA_W-1:0] top_v;
    logic [7:0]               depth_v;
    logic                     empty_v;
    logic                     full_v;
    logic [1:0]               status_v;
  } stack_view_t;

  logic signed [DATA_W-1:0] shadow_values [DEPTH];
  logic signed [DATA_W-1:0] shadow_minima [DEPTH];
  int                       value_fill;
  int                       minima_fill;
  stack_view_t              expected_views [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    value_fill  = 0;
    minima_fill = 0;
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d got %0d", $realtime, field, want, got);
    fail_count++;
  endtask

  // apply one operation to the shadow stacks and return the view afterwards
  task automatic apply_op(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                          output stack_view_t view);
    logic signed [DATA_W-1:0] popped;
    view.status_v = STAT_OK;
    if (op == FUNC_PUSH) begin
      if (value_fill >= DEPTH) begin
        view.status_v = STAT_FULL;
      end else begin
        shadow_values[value_fill] = val;
        value_fill++;
        if (minima_fill == 0) begin
          shadow_minima[0] = val;
          minima_fill = 1;
        end else if (minima_fill < DEPTH && val <= shadow_minima[minima_fill-1]) begin
          shadow_minima[minima_fill] = val;
          minima_fill++;
        end
      end
    end else if (op == FUNC_POP) begin
      if (value_fill == 0) begin
        view.status_v = STAT_EMPTY;
      end else begin
        popped = shadow_values[value_fill-1];
        value_fill--;
        if (minima_fill != 0 && popped == shadow_minima[minima_fill-1])
          minima_fill--;
      end
    end
    view.min_v   = (minima_fill != 0) ? shadow_minima[minima_fill-1] : '0;
    view.top_v   = (value_fill != 0) ? shadow_values[value_fill-1] : '0;
    view.depth_v = value_fill[7:0];
    view.empty_v = (value_fill == 0);
    view.full_v  = (value_fill >= DEPTH);
  endtask

  always @(posedge clk) begin
    stack_view_t want;
    stack_view_t got;
    if (rst) begin
      value_fill  = 0;
      minima_fill = 0;
      expected_views.delete();
      outstanding = 0;
    end else begin
      // results first: a result never belongs to the item taken at the same edge
      if (done) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result with no item outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          got  = '{min_value, top_value, depth, is_empty, is_full, status};
          if (got.min_v !== want.min_v) report_mismatch("min_value", want.min_v, got.min_v);
          if (got.top_v !== want.top_v) report_mismatch("top_value", want.top_v, got.top_v);
          if (got.depth_v !== want.depth_v)
            report_mismatch("depth", want.depth_v, got.depth_v);
          if (got.empty_v !== want.empty_v)
            report_mismatch("is_empty", want.empty_v, got.empty_v);
          if (got.full_v !== want.full_v)
            report_mismatch("is_full", want.full_v, got.full_v);
          if (got.status_v !== want.status_v)
            report_mismatch("status", want.status_v, got.status_v);
        end
      end
      if (start && !busy) begin
        apply_op(func, push_value, want);
        expected_views.push_back(want);
      end
      outstanding = expected_views.size();
    end
  end

endmodule

### sim/min_tracking_stack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_test
// drives push, pop and status items into the min tracking stack with random
// gaps, in phases that fill it to full, drain it past empty and mix the two;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module min_tracking_stack_test
  import mts_pkg::*;
();

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 2000;  // cycles with no item and no result taken
  localparam int PHASE_ITEMS = 175;   // random items in each of the four phases

  // spare selector, behaves as status only
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               func;
  logic signed [DATA_W-1:0] push_value;
  logic                     done;
  logic signed [DATA_W-1:0] min_value;
  logic signed [DATA_W-1:0] top_value;
  logic [7:0]               depth;
  logic                     is_empty;
  logic                     is_full;
  logic [1:0]               status;

  int   fail_count;
  int   outstanding;
  int   stall_cycles = 0;
  logic taken        = 1'b0;  // item taken at the most recent rising edge
  bit   gaps_on      = 1'b1;  // sender idling enabled

  min_tracking_stack #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .push_value(push_value),
    .done      (done),
    .min_value (min_value),
    .top_value (top_value),
    .depth     (depth),
    .is_empty  (is_empty),
    .is_full   (is_full),
    .status    (status)
  );

  min_tracking_stack_check #(
    .DEPTH(DEPTH)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .push_value (push_value),
    .done       (done),
    .min_value  (min_value),
    .top_value  (top_value),
    .depth      (depth),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .status     (status),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // handshake seen at the rising edge, read back at the following falling edge
  always @(posedge clk) taken <= !rst && start && !busy;

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("min_tracking_stack verification failed");
      $finish;
    end
  end

  // one item: optional idle cycles with noise on the fields, then hold start
  // until the block takes it; always entered and left at a falling edge
  task automatic send_item(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      start      <= 1'b0;
      func       <= 2'($urandom);
      push_value <= $urandom;
      @(negedge clk);
    end
    start      <= 1'b1;
    func       <= op;
    push_value <= val;
    @(negedge clk);
    while (!taken) @(negedge clk);
  endtask

  // hold off until every result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // many small values so that equal minima and ties turn up often
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // push and pop shares in percent, the rest split between status and the spare code
  function automatic logic [1:0] pick_op(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return FUNC_PUSH;
    if (roll < push_pct + pop_pct) return FUNC_POP;
    if (roll[0]) return FUNC_STATUS;
    return FUNC_SPARE;
  endfunction

  initial begin
    logic [1:0] op;
    rst        = 1'b1;
    start      = 1'b0;
    func       = FUNC_STATUS;
    push_value = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty stack, extremes, equal minima, unused selector
    send_item(FUNC_STATUS, '0);
    send_item(FUNC_POP, 32'sh7fff_ffff);        // refused, stack empty
    send_item(FUNC_SPARE, -32'sd1);             // unused selector acts as status
    send_item(FUNC_PUSH, 32'sh7fff_ffff);
    send_item(FUNC_PUSH, 32'sh8000_0000);       // new minimum
    send_item(FUNC_PUSH, 32'sh8000_0000);       // equal to minimum, tracked again
    send_item(FUNC_PUSH, '0);                   // above minimum, not tracked
    send_item(FUNC_STATUS, 32'sh5555_aaaa);
    send_item(FUNC_POP, '0);
    send_item(FUNC_POP, '0);                    // minimum stays, one copy left
    send_item(FUNC_POP, '0);                    // minimum back to the maximum
    send_item(FUNC_PUSH, -32'sd1);
    send_item(FUNC_PUSH, -32'sd1);
    send_item(FUNC_PUSH, 32'sd5);
    send_item(FUNC_SPARE, 32'sh8000_0000);
    send_item(FUNC_POP, '0);
    send_item(FUNC_POP, '0);
    send_item(FUNC_POP, '0);
    send_item(FUNC_POP, '0);                    // back to empty
    send_item(FUNC_POP, '0);                    // refused again
    send_item(FUNC_PUSH, -32'sd2);
    send_item(FUNC_POP, '0);
    drain_results();

    // random phases: fill past full, drain past empty, mix with no gaps, fill
    for (int phase = 0; phase < 4; phase++) begin
      gaps_on = (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case (phase)
          0, 3:    op = pick_op(88, 6);
          1:       op = pick_op(6, 88);
          default: op = pick_op(45, 45);
        endcase
        send_item(op, (op == FUNC_PUSH) ? pick_value() : DATA_W'($urandom));
      end
      if (phase == 1) drain_results();
    end

    // all items taken: wait for the last results, then a few quiet cycles
    drain_results();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("min_tracking_stack verification clean");
    end else begin
      $display("min_tracking_stack verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/min_tracking_stack.sv
rtl/mts_checker.sv
sim/min_tracking_stack_check.sv
sim/min_tracking_stack_test.sv
